@@ src/misf_pkg.sv @@
// Shared constants for the mains interference subtraction filter.
package misf_pkg;

  localparam int DEF_MAX_WINDOW  = 4096;
  localparam int DEF_SAMPLE_BITS = 24;

  localparam int CYC_50HZ = 25;
  localparam int CYC_60HZ = 30;
  localparam int CNTW     = 5;

  localparam int PW       = 8;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  localparam logic REG_MAINS_60HZ        = 1'b0;
  localparam logic REG_SAMPLES_PER_CYCLE = 1'b1;

  localparam logic          RST_MAINS_60HZ        = 1'b0;
  localparam logic [PW-1:0] RST_SAMPLES_PER_CYCLE = 8'd10;

endpackage

@@ src/mains_interference_subtract_filter.sv @@
// Mains interference subtraction filter: window store, sequencer and output register.
// Per sample, the C-entry phase walk goes through the single port of the window memory one
// entry per cycle, and the division by N takes one quotient bit per cycle in the divider.
// The next sample is taken once the current result sits in the output register. The window
// is cleared by reset or any register write at once, with no clearing pass: a fill count
// marks which entries hold data.
module mains_interference_subtract_filter #(
  parameter int MAX_WINDOW  = misf_pkg::DEF_MAX_WINDOW,
  parameter int SAMPLE_BITS = misf_pkg::DEF_SAMPLE_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [SAMPLE_BITS-1:0]       in_sample_in,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [SAMPLE_BITS-1:0]       out_sample_out,
  output logic                                out_saturated,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [misf_pkg::APB_AW-1:0]         paddr,
  input  logic [misf_pkg::APB_DW-1:0]         pwdata,
  output logic [misf_pkg::APB_DW-1:0]         prdata,
  output logic                                pready
);

  localparam int SB     = SAMPLE_BITS;
  localparam int AW     = $clog2(MAX_WINDOW);
  localparam int CW     = $clog2(MAX_WINDOW + 1);
  localparam int PW     = misf_pkg::PW;
  localparam int CNTW   = misf_pkg::CNTW;
  localparam int SAW    = SB + CW;
  localparam int SPW    = SB + CNTW;
  localparam int PRW    = SPW + PW + 1;
  localparam int NUMW   = ((PRW > SAW) ? PRW : SAW) + 1;
  localparam int QB     = SB + 2;
  localparam int YW     = SB + 3;
  localparam int NFW    = CNTW + PW;
  localparam int PMAX50 = MAX_WINDOW / misf_pkg::CYC_50HZ;
  localparam int PMAX60 = MAX_WINDOW / misf_pkg::CYC_60HZ;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_SUM   = 8'b0000_0010,
    ST_PHASE = 8'b0000_0100,
    ST_MUL   = 8'b0000_1000,
    ST_NUM   = 8'b0001_0000,
    ST_ABS   = 8'b0010_0000,
    ST_DIV   = 8'b0100_0000,
    ST_OUT   = 8'b1000_0000
  } state_t;

  state_t state_r;

  logic                   mains_60hz_r;
  logic [PW-1:0]          spc_r;
  logic [AW-1:0]          pos_r;
  logic [CW-1:0]          fill_r;
  logic signed [SAW-1:0]  s_all_r;
  logic signed [SPW-1:0]  s_phase_r;
  logic signed [SB-1:0]   x_r;
  logic [AW-1:0]          addr_r;
  logic [CNTW-1:0]        iss_cnt_r;
  logic                   pend_r;
  logic                   pend_ok_r;
  logic signed [PRW-1:0]  prod_r;
  logic signed [NUMW-1:0] num_r;
  logic                   neg_r;
  logic                   out_valid_r;
  logic signed [SB-1:0]   out_sample_r;
  logic                   out_sat_r;

  logic signed [SB-1:0]   mem [MAX_WINDOW];
  logic signed [SB-1:0]   rdata_r;
  logic [AW-1:0]          mem_addr;
  logic                   mem_we;

  logic [CNTW-1:0]        c_cur;
  logic [PW-1:0]          p_lo;
  logic [PW-1:0]          p_cur;
  logic [31:0]            pmax;
  logic [NFW-1:0]         n_full;
  logic [CW-1:0]          n_cur;
  logic [NUMW-1:0]        half;
  logic [AW-1:0]          pos_wrap;
  logic [AW-1:0]          addr_wrap;
  logic [CW:0]            pos_sum;
  logic [CW:0]            addr_sum;
  logic signed [SB-1:0]   old_val;
  logic signed [SB-1:0]   ph_val;
  logic signed [PRW-1:0]  prod_c;
  logic                   neg_c;
  logic [NUMW-1:0]        mag_c;
  logic                   div_start;
  logic                   div_done;
  logic [QB-1:0]          div_q;
  logic signed [YW-1:0]   y_c;
  logic signed [SB-1:0]   y_sat;
  logic                   y_ovf;
  logic                   out_load;
  logic                   cfg_wr;
  logic                   reg_idx;

  localparam logic signed [YW-1:0] SMAX = YW'((64'sd1 <<< (SB - 1)) - 64'sd1);
  localparam logic signed [YW-1:0] SMIN = YW'(-(64'sd1 <<< (SB - 1)));

  always_comb begin
    c_cur  = mains_60hz_r ? CNTW'(misf_pkg::CYC_60HZ) : CNTW'(misf_pkg::CYC_50HZ);
    pmax   = mains_60hz_r ? 32'(PMAX60) : 32'(PMAX50);
    p_lo   = (spc_r < PW'(2)) ? PW'(2) : spc_r;
    p_cur  = (32'(p_lo) > pmax) ? PW'(pmax) : p_lo;
    n_full = NFW'(c_cur) * NFW'(p_cur);
    n_cur  = CW'(n_full);
    half   = NUMW'(n_cur >> 1);
  end

  always_comb begin
    pos_sum   = (CW+1)'(pos_r) + (CW+1)'(1);
    pos_wrap  = (pos_sum >= (CW+1)'(n_cur)) ? '0 : AW'(pos_sum);
    addr_sum  = (CW+1)'(addr_r) + (CW+1)'(p_cur);
    addr_wrap = (addr_sum >= (CW+1)'(n_cur)) ? AW'(addr_sum - (CW+1)'(n_cur))
                                             : AW'(addr_sum);
  end

  always_comb begin
    mem_we   = (state_r == ST_SUM);
    mem_addr = (state_r == ST_PHASE) ? addr_r : pos_r;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= x_r;
    end
    rdata_r <= mem[mem_addr];
  end

  always_comb begin
    old_val = (CW'(pos_r) < fill_r) ? rdata_r : '0;
    ph_val  = pend_ok_r ? rdata_r : '0;
    prod_c  = $signed({1'b0, p_cur}) * s_phase_r;
    neg_c   = num_r[NUMW-1];
    mag_c   = neg_c ? (~num_r + (half + NUMW'(1))) : (num_r + half);
  end

  assign div_start = (state_r == ST_ABS);

  misf_div #(
    .MAGW (NUMW),
    .CW   (CW),
    .QB   (QB)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (mag_c),
    .divisor  (n_cur),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    y_c = neg_r ? (YW'(x_r) + $signed(YW'(div_q))) : (YW'(x_r) - $signed(YW'(div_q)));
    priority if (y_c > SMAX) begin
      y_sat = SB'(SMAX);
      y_ovf = 1'b1;
    end else if (y_c < SMIN) begin
      y_sat = SB'(SMIN);
      y_ovf = 1'b1;
    end else begin
      y_sat = SB'(y_c);
      y_ovf = 1'b0;
    end
  end

  assign out_load = (state_r == ST_OUT) && (!out_valid_r || out_ready);
  assign cfg_wr   = psel && penable && pwrite;
  assign reg_idx  = paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      mains_60hz_r <= misf_pkg::RST_MAINS_60HZ;
      spc_r        <= misf_pkg::RST_SAMPLES_PER_CYCLE;
      pos_r        <= '0;
      fill_r       <= '0;
      s_all_r      <= '0;
      pend_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            x_r     <= in_sample_in;
            state_r <= ST_SUM;
          end
        end
        ST_SUM: begin
          s_all_r   <= s_all_r - SAW'(old_val) + SAW'(x_r);
          if (fill_r < n_cur) begin
            fill_r <= fill_r + CW'(1);
          end
          pos_r     <= pos_wrap;
          s_phase_r <= SPW'(x_r);
          iss_cnt_r <= CNTW'(1);
          pend_r    <= 1'b0;
          addr_r    <= AW'(((CW+1)'(pos_r) + (CW+1)'(p_cur) >= (CW+1)'(n_cur))
                           ? ((CW+1)'(pos_r) + (CW+1)'(p_cur) - (CW+1)'(n_cur))
                           : ((CW+1)'(pos_r) + (CW+1)'(p_cur)));
          state_r   <= ST_PHASE;
        end
        ST_PHASE: begin
          if (pend_r) begin
            s_phase_r <= s_phase_r + SPW'(ph_val);
          end
          if (iss_cnt_r < c_cur) begin
            pend_r    <= 1'b1;
            pend_ok_r <= (CW'(addr_r) < fill_r);
            addr_r    <= addr_wrap;
            iss_cnt_r <= iss_cnt_r + CNTW'(1);
          end else begin
            pend_r <= 1'b0;
            if (!pend_r) begin
              state_r <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          prod_r  <= prod_c;
          state_r <= ST_NUM;
        end
        ST_NUM: begin
          num_r   <= NUMW'(prod_r) - NUMW'(s_all_r);
          state_r <= ST_ABS;
        end
        ST_ABS: begin
          neg_r   <= neg_c;
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            state_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            out_sample_r <= y_sat;
            out_sat_r    <= y_ovf;
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
      if (cfg_wr) begin
        if (reg_idx == misf_pkg::REG_MAINS_60HZ) begin
          mains_60hz_r <= pwdata[0];
        end else begin
          spc_r <= pwdata[PW-1:0];
        end
        pos_r   <= '0;
        fill_r  <= '0;
        s_all_r <= '0;
      end
    end
  end

  always_comb begin
    if (reg_idx == misf_pkg::REG_MAINS_60HZ) begin
      prdata = misf_pkg::APB_DW'(mains_60hz_r);
    end else begin
      prdata = misf_pkg::APB_DW'(spc_r);
    end
  end

  assign pready         = 1'b1;
  assign in_ready       = (state_r == ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_saturated  = out_sat_r;

`ifndef SYNTHESIS
  a_pos_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    (CW'(pos_r) < n_cur))
    else $error("write position outside the window");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r <= n_cur))
    else $error("fill count exceeds the window length");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input ready right after a transfer");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV))
    else $error("divider finished outside the divide step");
`endif

endmodule

@@ src/misf_div.sv @@
// Restoring divider, one quotient bit per cycle.
module misf_div #(
  parameter int MAGW = 40,
  parameter int CW   = 13,
  parameter int QB   = 26
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [MAGW-1:0] dividend,
  input  logic [CW-1:0]   divisor,
  output logic            done,
  output logic [QB-1:0]   quotient
);

  localparam int QCW = $clog2(QB + 1);

  logic [CW-1:0]  rem_r;
  logic [CW-1:0]  rem_nxt;
  logic [QB-1:0]  dvd_r;
  logic [QB-1:0]  q_r;
  logic [QCW-1:0] cnt_r;
  logic           done_r;
  logic [CW:0]    trial;
  logic           ge;

  always_comb begin
    trial   = {rem_r, dvd_r[QB-1]};
    ge      = trial >= {1'b0, divisor};
    rem_nxt = ge ? CW'(trial - {1'b0, divisor}) : trial[CW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (start) begin
      cnt_r  <= QCW'(QB);
      done_r <= 1'b0;
    end else if (cnt_r != '0) begin
      cnt_r  <= cnt_r - QCW'(1);
      done_r <= (cnt_r == QCW'(1));
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= CW'(dividend >> QB);
      dvd_r <= dividend[QB-1:0];
      q_r   <= '0;
    end else if (cnt_r != '0) begin
      rem_r <= rem_nxt;
      dvd_r <= {dvd_r[QB-2:0], 1'b0};
      q_r   <= {q_r[QB-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule
